### hw/rtl/cpglu_pkg.sv
// ----------------------------------------------------------------------------
// cpglu_pkg
// Shared types and constants of the codepoint to glyph lookup block:
// beat payloads, opcodes, register indexes and default table depth.
// ----------------------------------------------------------------------------
package cpglu_pkg;

  // field widths fixed by the interface
  localparam int unsigned CP_W      = 21;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned GI_W      = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // default number of table entries
  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  // item opcodes
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_PRES  = 2'd3;

  // input beat
  typedef struct packed {
    opcode_e          opcode;
    logic [IDX_W-1:0] entry_index;
    logic [CP_W-1:0]  codepoint;
  } in_t;

  // output beat
  typedef struct packed {
    logic            found;
    logic [GI_W-1:0] glyph_id;
  } out_t;

endpackage

### hw/rtl/cpglu_ram.sv
// ----------------------------------------------------------------------------
// cpglu_ram
// Generic single-write, single-read synchronous RAM with registered read
// data. Contents are not reset.
// ----------------------------------------------------------------------------
module cpglu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/codepoint_to_glyph_lookup_top.sv
// ----------------------------------------------------------------------------
// codepoint_to_glyph_lookup_top
// Maps a codepoint to a glyph index through a direct range and a binary
// search over a sorted codepoint table held in a synchronous RAM.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries load and lookup
//   beats. A load writes one table entry in its accept cycle and gives no
//   output beat; loads at or beyond the table depth are dropped.
//   A lookup gives exactly one output beat (out_valid_o/out_ready_i/
//   out_data_o) with found and glyph index (0 when not found).
//   A lookup passes ST_START, then ST_SEARCH while it probes the table,
//   then ST_FIN; a search makes at most ceil(log2(len + 1)) probes, with
//   len the searched length. The search does one RAM read per cycle; the
//   next probe address is formed from the read data of the previous probe
//   in the same cycle. One lookup is in flight at a time; in_ready_o is
//   high between lookups. The output register decouples the receiver: a
//   new item is accepted while a result waits, and a finished lookup holds
//   until it drains. Reset clears the configuration registers and control
//   state; table contents are undefined until loaded. The user must write
//   registers via cfg_we_i only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module codepoint_to_glyph_lookup_top
  import cpglu_pkg::*;
#(
  parameter int unsigned TableDepth = TABLE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o
);

  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned LenW  = AddrW + 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SEARCH,
    ST_FIN
  } state_e;

  // configuration registers
  logic [CFG_W-1:0] dir_base_q, map_count_q, glyph_count_q;
  logic             table_pres_q;

  // sequencer state
  state_e                 state_q, state_d;
  logic [CP_W-1:0]        key_q, key_d;
  logic signed [LenW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [AddrW-1:0]       mid_q, mid_d;
  logic                   res_found_q, res_found_d;
  logic [GI_W-1:0]        res_gi_q, res_gi_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;

  // table RAM ports
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [CP_W-1:0]  ram_rdata;
  logic [31:0]      idx_ext;

  // datapath helpers
  logic                   in_acc;
  logic [CP_W-1:0]        dir_off;
  logic                   dir_hit;
  logic signed [CFG_W:0]  len_diff;
  logic signed [LenW-1:0] len_s, nlo, nhi, span;
  logic signed [LenW-1:0] mid_s, mid_n;

  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_base_q    <= '0;
      map_count_q   <= '0;
      glyph_count_q <= '0;
      table_pres_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAP_START:   dir_base_q    <= cfg_data_i;
        REG_MAP_COUNT:   map_count_q   <= cfg_data_i;
        REG_GLYPH_COUNT: glyph_count_q <= cfg_data_i;
        REG_TABLE_PRES:  table_pres_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // load beats write the table directly
  assign idx_ext   = 32'(in_data_i.entry_index);
  assign ram_waddr = idx_ext[AddrW-1:0];
  assign ram_we    = in_acc && (in_data_i.opcode == OP_LOAD) &&
                     (idx_ext < 32'(TableDepth));

  cpglu_ram #(
    .Width (CP_W),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_data_i.codepoint),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // direct range check
  assign dir_off = key_q - CP_W'(dir_base_q);
  assign dir_hit = (key_q >= CP_W'(dir_base_q)) && (dir_off < CP_W'(map_count_q));

  // search length, clamped to the table depth
  assign len_diff = $signed({1'b0, glyph_count_q}) - $signed({1'b0, map_count_q});
  assign len_s    = (len_diff > $signed((CFG_W + 1)'(TableDepth))) ?
                    LenW'(TableDepth) : LenW'(len_diff);

  // bounds after the current probe
  assign mid_s = $signed({2'b00, mid_q});
  always_comb begin
    nlo = lo_q;
    nhi = hi_q;
    if (ram_rdata < key_q) begin
      nlo = mid_s + LenW'(1);
    end else begin
      nhi = mid_s - LenW'(1);
    end
  end

  // next probe midpoint from the bounds the current state selects
  always_comb begin
    if (state_q == ST_START) begin
      span  = len_s - LenW'(1);
      mid_n = span >>> 1;
    end else begin
      span  = nhi - nlo;
      mid_n = nlo + (span >>> 1);
    end
  end
  assign ram_raddr = mid_n[AddrW-1:0];

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    res_found_d = res_found_q;
    res_gi_d    = res_gi_q;
    ram_re      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.opcode == OP_LOOKUP)) begin
          key_d   = in_data_i.codepoint;
          state_d = ST_START;
        end
      end
      ST_START: begin
        res_found_d = 1'b0;
        res_gi_d    = '0;
        state_d     = ST_FIN;
        if (dir_hit) begin
          if (dir_off[GI_W-1:0] < glyph_count_q) begin
            res_found_d = 1'b1;
            res_gi_d    = dir_off[GI_W-1:0];
          end
        end else if (table_pres_q && (len_diff > 0)) begin
          // first probe over the whole range
          lo_d    = '0;
          hi_d    = len_s - LenW'(1);
          mid_d   = mid_n[AddrW-1:0];
          ram_re  = 1'b1;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (ram_rdata == key_q) begin
          res_found_d = 1'b1;
          res_gi_d    = map_count_q + GI_W'(mid_q);
          state_d     = ST_FIN;
        end else if (nlo <= nhi) begin
          lo_d   = nlo;
          hi_d   = nhi;
          mid_d  = mid_n[AddrW-1:0];
          ram_re = 1'b1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          out_d.found    = res_found_q;
          out_d.glyph_id = res_gi_q;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    res_found_q <= res_found_d;
    res_gi_q    <= res_gi_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // table is written only between lookups
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE))
    else $error("table write during lookup");

  // probe stays inside the live search window
  a_probe_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> ((lo_q <= mid_s) && (mid_s <= hi_q)))
    else $error("probe outside search window");

  // every search cycle was preceded by a read of the probed entry
  a_read_before_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> $past(ram_re))
    else $error("compare without a table read");

  // a miss reports glyph index zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.found) |-> (out_q.glyph_id == '0))
    else $error("miss with nonzero glyph index");

  // a found index lies below the glyph count
  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && res_found_q) |-> (res_gi_q < glyph_count_q))
    else $error("found index beyond glyph count");

endmodule
